### sv/mac_header_sender_extract_core_assert.svh
// Assertion macros for the MAC header sender-address extractor.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef MAC_HEADER_SENDER_EXTRACT_CORE_ASSERT_SVH
`define MAC_HEADER_SENDER_EXTRACT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted
`define MHSE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset
`define MHSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MHSE_ASSERT(lbl, clk, rst_n, prop, msg)
`define MHSE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### sv/mhse_pkg.sv
// Shared types, codes and header-decode helpers for the sender-address extractor.
// No dependencies.
`default_nettype none

package mhse_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_TOO_SHORT = 3'd0,
    ST_NONE      = 3'd1,
    ST_SHORT     = 3'd2,
    ST_LONG      = 3'd3,
    ST_TRUNC     = 3'd4,
    ST_RESERVED  = 3'd5
  } status_t;

  // Addressing mode codes of the frame control field
  typedef enum logic [1:0] {
    AM_NONE  = 2'd0,
    AM_RSVD  = 2'd1,
    AM_SHORT = 2'd2,
    AM_LONG  = 2'd3
  } addr_mode_t;

  localparam int unsigned DATA_W    = 8;
  localparam int unsigned LEN_W     = 8;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned POS_W     = 5;   // header positions stay below 24
  localparam logic [CFG_W-1:0] MIN_LEN_RST = 7'd3;

  // One accepted input beat
  typedef struct packed {
    logic [LEN_W-1:0]  flen;
    logic              sof;
    logic [DATA_W-1:0] data;
  } beat_t;

  // Offset of the first source-address byte in the frame
  function automatic logic [POS_W-1:0] src_offset(input logic [15:0] fcf);
    logic [POS_W-1:0] off;
    off = 5'd3;
    case (addr_mode_t'(fcf[11:10]))
      AM_NONE:  off = off;
      AM_SHORT: off = off + 5'd4;
      AM_LONG:  off = off + 5'd10;
      default:  off = off + 5'd2;   // reserved mode: PAN only
    endcase
    if (!fcf[6]) off = off + 5'd2;  // source PAN present
    return off;
  endfunction

  // Source address length in bytes
  function automatic logic [POS_W-1:0] src_len(input logic [15:0] fcf);
    return (addr_mode_t'(fcf[15:14]) == AM_LONG) ? 5'd8 : 5'd2;
  endfunction

endpackage

`default_nettype wire

### sv/mac_header_sender_extract_core.sv
// Top level of the 802.15.4 MAC header sender-address extractor.
// An accepted beat passes the input register, then the result register, to the output.
// Throughput: one frame byte per cycle, set by the single-pass parser between the
// input register and the result register; stalls only on output backpressure.
// Reset (rst_n low, synchronous): no frame active, address store zero,
// min_frame_len 3, both registers empty.
`default_nettype none

module mac_header_sender_extract_core
  import mhse_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [6:0]  cfg_data,    // min_frame_len
  // frame byte stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,    // [7:0] data_byte, [15:8] frame_len
  input  wire logic        in_tuser,    // [0] start_of_frame
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata    // [2:0] status, [66:3] sender_address,
                                        // [69:67] frame kind, [70] ack_request, [71] zero
);

  beat_t             in_beat, beat;
  logic              beat_valid, advance;
  status_t           res_status;
  logic [ADDR_W-1:0] res_addr;
  logic [2:0]        res_ftype;
  logic              res_ack;

  assign in_beat = '{flen: in_tdata[15:8], sof: in_tuser, data: in_tdata[7:0]};

  mhse_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_beat    (in_beat),
    .advance    (advance),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  mhse_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .beat_valid (beat_valid),
    .beat       (beat),
    .advance    (advance),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_status (res_status),
    .res_addr   (res_addr),
    .res_ftype  (res_ftype),
    .res_ack    (res_ack)
  );

  assign out_tdata = {1'b0, res_ack, res_ftype, res_addr, res_status};

endmodule

`default_nettype wire

### sv/mhse_in_stage.sv
// Input register stage: holds one accepted beat until the parser consumes it.
// Depends on mhse_pkg and the assertion header.
`default_nettype none

module mhse_in_stage
  import mhse_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire beat_t in_beat,
  input  wire logic  advance,    // downstream takes the held beat this cycle
  output logic       beat_valid,
  output beat_t      beat
);

  logic  valid_r, valid_nxt;
  beat_t beat_r;

  assign in_ready   = !valid_r || advance;
  assign valid_nxt  = in_ready ? in_valid : valid_r;
  assign beat_valid = valid_r;
  assign beat       = beat_r;

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, loaded on every accepted beat
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat_r <= in_beat;
    end
  end

`include "mac_header_sender_extract_core_assert.svh"
  `MHSE_ASSERT(a_hold_unconsumed, clk, rst_n, valid_r && !advance |=> valid_r, "beat lost")
  `MHSE_ASSERT(a_load_on_free, clk, rst_n, !valid_r && in_valid |=> valid_r, "beat not taken")
  `MHSE_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !valid_r, "reset left beat")

endmodule

`default_nettype wire

### sv/mhse_parser.sv
// Header parser: frame position state, address store and result register.
// Depends on mhse_pkg and the assertion header.
`default_nettype none

module mhse_parser
  import mhse_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire logic              beat_valid,
  input  wire beat_t             beat,
  output logic                   advance,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output status_t                res_status,
  output logic [ADDR_W-1:0]      res_addr,
  output logic [2:0]             res_ftype,
  output logic                   res_ack
);

  // Configuration and frame state
  logic [CFG_W-1:0]  min_len_r;
  logic              active_r, active_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [15:0]       ctrl_r, ctrl_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;

  // Result register
  logic              res_valid_r;
  status_t           res_status_r;
  logic [ADDR_W-1:0] res_addr_r;
  logic [2:0]        res_ftype_r;
  logic              res_ack_r;

  logic              step;
  logic              emit;
  status_t           status_w;
  logic [2:0]        ftype_w;
  logic              ack_w;
  logic [15:0]       ctrl_w;
  logic [POS_W-1:0]  start_w, alen_w, end_w, pos_inc;
  logic [2:0]        k_w, dst_w;
  logic              in_range;

  assign cfg_ready = 1'b1;
  assign advance   = !res_valid_r || res_ready;
  assign step      = beat_valid && advance;

  // Header geometry from the control field as it stands after this beat
  assign ctrl_w   = (pos_r == 5'd1) ? {beat.data, ctrl_r[7:0]} : ctrl_r;
  assign start_w  = src_offset(ctrl_w);
  assign alen_w   = src_len(ctrl_w);
  assign end_w    = start_w + alen_w;
  assign pos_inc  = pos_r + 5'd1;
  assign in_range = (pos_r >= start_w) && (pos_r < end_w);
  assign k_w      = 3'(pos_r - start_w);
  assign dst_w    = (alen_w == 5'd8) ? (3'd7 - k_w) : (3'd1 - k_w);

  // Next state and result for one beat
  always_comb begin
    active_nxt = active_r;
    pos_nxt    = pos_r;
    ctrl_nxt   = ctrl_r;
    len_nxt    = len_r;
    addr_nxt   = addr_r;
    emit       = 1'b0;
    status_w   = ST_NONE;
    ftype_w    = ctrl_r[2:0];
    ack_w      = ctrl_r[5];
    if (step) begin
      if (beat.sof) begin
        active_nxt = 1'b0;
        pos_nxt    = '0;
        len_nxt    = beat.flen;
        ctrl_nxt   = {8'h00, beat.data};
        ftype_w    = beat.data[2:0];
        ack_w      = beat.data[5];
        if (beat.flen <= {1'b0, min_len_r}) begin
          emit     = 1'b1;
          status_w = ST_TOO_SHORT;
          ack_w    = 1'b0;
        end else if (beat.flen < 8'd2) begin
          emit     = 1'b1;
          status_w = ST_TRUNC;
        end else begin
          active_nxt = 1'b1;
          pos_nxt    = 5'd1;
        end
      end else if (active_r) begin
        if (pos_r == 5'd1) begin
          // second control byte: source mode decides the rest
          ctrl_nxt = ctrl_w;
          case (addr_mode_t'(ctrl_w[15:14]))
            AM_NONE: begin
              addr_nxt = '0;
              emit     = 1'b1;
              status_w = ST_NONE;
            end
            AM_RSVD: begin
              emit     = 1'b1;
              status_w = ST_RESERVED;
            end
            default: begin
              if ({3'b000, end_w} > len_r) begin
                emit     = 1'b1;
                status_w = ST_TRUNC;
              end else begin
                pos_nxt = 5'd2;
              end
            end
          endcase
        end else begin
          // skip header bytes, capture address bytes reversed
          for (int i = 0; i < 8; i++) begin
            if (in_range && dst_w == 3'(i)) begin
              addr_nxt[8*i +: 8] = beat.data;
            end
          end
          pos_nxt = pos_inc;
          if (pos_inc >= end_w) begin
            emit     = 1'b1;
            status_w = (alen_w == 5'd8) ? ST_LONG : ST_SHORT;
          end
        end
      end
      if (emit) active_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r   <= MIN_LEN_RST;
      active_r    <= 1'b0;
      pos_r       <= '0;
      ctrl_r      <= '0;
      len_r       <= '0;
      addr_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) min_len_r <= cfg_data;
      active_r <= active_nxt;
      pos_r    <= pos_nxt;
      ctrl_r   <= ctrl_nxt;
      len_r    <= len_nxt;
      addr_r   <= addr_nxt;
      if (advance) res_valid_r <= emit;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res_status_r <= status_w;
      res_addr_r   <= addr_nxt;
      res_ftype_r  <= ftype_w;
      res_ack_r    <= ack_w;
    end
  end

  assign res_valid  = res_valid_r;
  assign res_status = res_status_r;
  assign res_addr   = res_addr_r;
  assign res_ftype  = res_ftype_r;
  assign res_ack    = res_ack_r;

`include "mac_header_sender_extract_core_assert.svh"
  `MHSE_ASSERT(a_pos_range, clk, rst_n, active_r |-> pos_r >= 5'd1 && pos_r <= 5'd23, "bad pos")
  `MHSE_ASSERT(a_none_clears, clk, rst_n, res_valid_r && res_status_r == ST_NONE |-> res_addr_r == '0, "store not cleared")
  `MHSE_ASSERT(a_short_no_ack, clk, rst_n, res_valid_r && res_status_r == ST_TOO_SHORT |-> !res_ack_r, "ack on short frame")
  `MHSE_ASSERT(a_emit_ends_frame, clk, rst_n, step && emit |=> !active_r, "frame still active")

endmodule

`default_nettype wire
